/* design/bdl_pkg.sv */
package bdl_pkg;

  localparam int CapacityDef   = 32;
  localparam int ValueWidthDef = 32;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_INS_AFTER = 3'd1;
  localparam logic [2:0] ACT_INS_BACK  = 3'd2;
  localparam logic [2:0] ACT_DEL_FRONT = 3'd3;
  localparam logic [2:0] ACT_DEL_POS   = 3'd4;
  localparam logic [2:0] ACT_DEL_BACK  = 3'd5;
  localparam logic [2:0] ACT_TRAVERSE  = 3'd6;
  localparam logic [2:0] ACT_NONE      = 3'd7;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_BADPOS = 3'd1;
  localparam logic [2:0] ST_RANGE  = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_FULL   = 3'd4;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
    logic [5:0]         position;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] item_value;
    logic               last;
    logic [5:0]         element_count;
  } rsp_t;

  typedef struct packed {
    logic accept;
    logic walk_step;
    logic walk_done_ins;
    logic link1;
    logic link2;
    logic unlink;
    logic emit_single;
    logic emit_trav;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] chk_status;
    logic       walk_hit;
    logic       trav_last;
    logic       out_free;
  } dp_sts_t;

endpackage

/* design/bdl_ram.sv */
module bdl_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/bdl_ctrl.sv */
module bdl_ctrl
  import bdl_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [2:0] action_i,
  input  dp_sts_t    sts_i,
  output logic       in_stall_o,
  output dp_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_LINK1  = 3'd2;
  localparam logic [2:0] S_LINK2  = 3'd3;
  localparam logic [2:0] S_UNLINK = 3'd4;
  localparam logic [2:0] S_EMIT   = 3'd5;
  localparam logic [2:0] S_TRAV   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [2:0] act_q, act_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          act_d        = action_i;
          if (sts_i.chk_status != ST_OK || action_i == ACT_NONE) begin
            state_d = S_EMIT;
          end else begin
            case (action_i)
              ACT_INS_FRONT, ACT_INS_BACK: state_d = S_LINK1;
              ACT_INS_AFTER, ACT_DEL_POS:  state_d = S_WALK;
              ACT_DEL_FRONT, ACT_DEL_BACK: state_d = S_UNLINK;
              ACT_TRAVERSE:                state_d = S_TRAV;
              default:                     state_d = S_EMIT;
            endcase
          end
        end
      end
      S_WALK: begin
        if (sts_i.walk_hit) begin
          if (act_q == ACT_INS_AFTER) begin
            cmd_o.walk_done_ins = 1'b1;
            state_d             = S_LINK1;
          end else begin
            state_d = S_UNLINK;
          end
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      S_LINK1: begin
        cmd_o.link1 = 1'b1;
        state_d     = S_LINK2;
      end
      S_LINK2: begin
        cmd_o.link2 = 1'b1;
        state_d     = S_EMIT;
      end
      S_UNLINK: begin
        cmd_o.unlink = 1'b1;
        state_d      = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_single = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_TRAV: begin
        if (sts_i.out_free) begin
          cmd_o.emit_trav = 1'b1;
          if (sts_i.trav_last) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      act_q   <= ACT_NONE;
    end else begin
      state_q <= state_d;
      act_q   <= act_d;
    end
  end

endmodule

/* design/bdl_datapath.sv */
module bdl_datapath
  import bdl_pkg::*;
#(
  parameter int CAPACITY    = CapacityDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    in_data_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output rsp_t    out_data_o
);

  localparam int IW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NulLink = LW'(CAPACITY);
  localparam logic [LW-1:0] CapCount = LW'(CAPACITY);

  logic [LW-1:0] head_q, head_d, tail_q, tail_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] bef_q, bef_d, aft_q, aft_d;
  logic [LW-1:0] count_q, count_d;
  logic [LW-1:0] k_q, k_d;
  logic [IW-1:0] node_q;
  logic [2:0]    status_q;
  logic [5:0]    pos_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CAPACITY-1:0] fs_vld_q;
  logic [IW-1:0] fs_raddr_q;
  logic          fs_rvld_q;
  logic          out_valid_q;
  rsp_t          out_q;

  logic [VALUE_WIDTH-1:0] val_rd;
  logic [LW-1:0] nxt_rd, prv_rd;
  logic [IW-1:0] fs_rd, fs_out, fs_raddr;
  logic [IW-1:0] rd_addr;

  logic          nxt_we, prv_we, fs_we;
  logic [IW-1:0] nxt_waddr, prv_waddr, fs_waddr;
  logic [LW-1:0] nxt_wdata, prv_wdata;
  logic [LW-1:0] count_m1;

  logic full, empty;
  logic [2:0] chk;

  assign full     = (count_q == CapCount);
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - LW'(1);

  always_comb begin
    chk = ST_OK;
    case (in_data_i.action)
      ACT_INS_FRONT, ACT_INS_BACK: chk = full ? ST_FULL : ST_OK;
      ACT_INS_AFTER: begin
        if (in_data_i.position == '0) chk = ST_BADPOS;
        else if (8'(in_data_i.position) > 8'(count_q)) chk = ST_RANGE;
        else if (full) chk = ST_FULL;
      end
      ACT_DEL_FRONT, ACT_DEL_BACK, ACT_TRAVERSE: chk = empty ? ST_EMPTY : ST_OK;
      ACT_DEL_POS: begin
        if (in_data_i.position == '0) chk = ST_BADPOS;
        else if (empty) chk = ST_EMPTY;
        else if (8'(in_data_i.position) > 8'(count_q)) chk = ST_RANGE;
      end
      default: chk = ST_OK;
    endcase
  end

  assign sts_o.chk_status = chk;
  assign sts_o.walk_hit   = (8'(k_q) == 8'(pos_q));
  assign sts_o.trav_last  = (8'(k_q) == 8'(count_q));
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign fs_raddr = full ? '0 : count_q[IW-1:0];
  assign fs_out   = fs_rvld_q ? fs_rd : fs_raddr_q;

  always_comb begin
    cur_d = cur_q;
    if (cmd_i.accept) begin
      cur_d = (in_data_i.action == ACT_DEL_BACK) ? tail_q : head_q;
    end else if (cmd_i.walk_step || cmd_i.emit_trav) begin
      cur_d = nxt_rd;
    end
  end
  assign rd_addr = cur_d[IW-1:0];

  always_comb begin
    bef_d = bef_q;
    aft_d = aft_q;
    if (cmd_i.accept) begin
      if (in_data_i.action == ACT_INS_FRONT) begin
        bef_d = NulLink;
        aft_d = head_q;
      end else begin
        bef_d = tail_q;
        aft_d = NulLink;
      end
    end else if (cmd_i.walk_done_ins) begin
      bef_d = cur_q;
      aft_d = nxt_rd;
    end
  end

  always_comb begin
    k_d = k_q;
    if (cmd_i.accept) k_d = LW'(1);
    else if (cmd_i.walk_step || cmd_i.emit_trav) k_d = k_q + LW'(1);
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = fs_out;
    nxt_wdata = aft_q;
    prv_we    = 1'b0;
    prv_waddr = fs_out;
    prv_wdata = bef_q;
    head_d    = head_q;
    tail_d    = tail_q;
    count_d   = count_q;
    fs_we     = 1'b0;
    fs_waddr  = count_m1[IW-1:0];
    if (cmd_i.link1) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (cmd_i.link2) begin
      nxt_waddr = bef_q[IW-1:0];
      nxt_wdata = LW'(node_q);
      prv_waddr = aft_q[IW-1:0];
      prv_wdata = LW'(node_q);
      if (bef_q != NulLink) nxt_we = 1'b1;
      else head_d = LW'(node_q);
      if (aft_q != NulLink) prv_we = 1'b1;
      else tail_d = LW'(node_q);
      count_d = count_q + LW'(1);
    end else if (cmd_i.unlink) begin
      nxt_waddr = prv_rd[IW-1:0];
      nxt_wdata = nxt_rd;
      prv_waddr = nxt_rd[IW-1:0];
      prv_wdata = prv_rd;
      if (prv_rd != NulLink) nxt_we = 1'b1;
      else head_d = nxt_rd;
      if (nxt_rd != NulLink) prv_we = 1'b1;
      else tail_d = prv_rd;
      count_d = count_m1;
      fs_we   = 1'b1;
    end
  end

  bdl_ram #(.Width(VALUE_WIDTH), .Depth(CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.link1),
    .waddr_i (fs_out),
    .wdata_i (value_q),
    .raddr_i (rd_addr),
    .rdata_o (val_rd)
  );

  bdl_ram #(.Width(LW), .Depth(CAPACITY)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (rd_addr),
    .rdata_o (nxt_rd)
  );

  bdl_ram #(.Width(LW), .Depth(CAPACITY)) u_prv_ram (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prv_rd)
  );

  bdl_ram #(.Width(IW), .Depth(CAPACITY)) u_fs_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (cur_q[IW-1:0]),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= NulLink;
      tail_q      <= NulLink;
      count_q     <= '0;
      fs_vld_q    <= '0;
      fs_rvld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      count_q   <= count_d;
      fs_rvld_q <= fs_vld_q[fs_raddr];
      if (fs_we) fs_vld_q[fs_waddr] <= 1'b1;
      if (cmd_i.emit_single || cmd_i.emit_trav) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    bef_q      <= bef_d;
    aft_q      <= aft_d;
    k_q        <= k_d;
    fs_raddr_q <= fs_raddr;
    if (cmd_i.accept) begin
      status_q <= chk;
      pos_q    <= in_data_i.position;
      value_q  <= VALUE_WIDTH'(in_data_i.value);
    end
    if (cmd_i.link1) node_q <= fs_out;
    if (cmd_i.emit_single) begin
      out_q.status        <= status_q;
      out_q.item_value    <= '0;
      out_q.last          <= 1'b1;
      out_q.element_count <= 6'(count_q);
    end else if (cmd_i.emit_trav) begin
      out_q.status        <= ST_OK;
      out_q.item_value    <= $signed(32'(val_rd));
      out_q.last          <= sts_o.trav_last;
      out_q.element_count <= 6'(count_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* design/bounded_doubly_linked_list_unit.sv */
// Steps from accept to result: a rejected or ignored request goes straight to the emit state; a front
// or back delete unlinks, then emits; a front or back insert links in two steps, then emits; delete-at
// and insert-after first walk to the position, reading one link per cycle; traverse emits its values.
// Throughput: one request at a time; the next is accepted once the controller is idle again after the
// last result; traverse emits one transfer per cycle while the output is not stalled.
// A stalled output holds the result. Reset: asynchronous, active low; list empty, all nodes free.
module bounded_doubly_linked_list_unit
  import bdl_pkg::*;
#(
  parameter int CAPACITY    = CapacityDef,
  parameter int VALUE_WIDTH = ValueWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  bdl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (in_data_i.action),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  bdl_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
